[rtl/swtv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swtv_pkg
// Shared constants and controller/datapath types for the tile visibility block.
// ----------------------------------------------------------------------------
package swtv_pkg;

	localparam int COORD_W  = 10;   // tile coordinate width
	localparam int SPAN_W   = 11;   // coordinate plus one, for window ends
	localparam int GRID_W   = 11;   // grid size register width
	localparam int RADIUS_W = 2;    // sight radius register width

	localparam logic [GRID_W-1:0]   GRID_MAX  = GRID_W'(1024);
	localparam logic [RADIUS_W-1:0] MAX_SIGHT = RADIUS_W'(2);

	localparam logic [GRID_W-1:0]   GRID_WIDTH_RST   = GRID_W'(1024);
	localparam logic [GRID_W-1:0]   GRID_HEIGHT_RST  = GRID_W'(1024);
	localparam logic [RADIUS_W-1:0] SIGHT_RADIUS_RST = RADIUS_W'(1);

	// configuration register byte addresses
	localparam int PADDR_W = 4;
	localparam logic [PADDR_W-1:0] ADDR_GRID_WIDTH   = 4'h0;
	localparam logic [PADDR_W-1:0] ADDR_GRID_HEIGHT  = 4'h4;
	localparam logic [PADDR_W-1:0] ADDR_SIGHT_RADIUS = 4'h8;

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_MOVE  = 1'b1;

	typedef struct packed {
		logic load;       // latch accepted item
		logic start_old;  // begin scan of old window
		logic start_new;  // begin scan of new window
		logic step;       // consume current candidate
		logic flush;      // push pending result flagged last
		logic commit;     // store new center
	} swtv_cmd_t;

	typedef struct packed {
		logic is_move;
		logic same_center;
		logic phase_old;
		logic hit;         // current candidate produces a result
		logic at_end;      // current candidate is the last of its window
		logic pend_valid;
		logic out_free;
	} swtv_sts_t;

endpackage
`default_nettype wire

[rtl/swtv_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swtv_in_if / swtv_out_if
// Valid/ready channels for center items and tile visibility results.
// ----------------------------------------------------------------------------
interface swtv_in_if import swtv_pkg::*; ;
	logic               valid;
	logic               ready;
	logic               action;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;

	modport source (output valid, action, center_x, center_y, input ready);
	modport sink   (input valid, action, center_x, center_y, output ready);
endinterface

interface swtv_out_if import swtv_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] tile_x;
	logic [COORD_W-1:0] tile_y;
	logic               page_visible;
	logic               last;

	modport source (output valid, tile_x, tile_y, page_visible, last, input ready);
	modport sink   (input valid, tile_x, tile_y, page_visible, last, output ready);
endinterface
`default_nettype wire

[rtl/sliding_window_tile_visibility.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_tile_visibility
// Reports the tiles of a square sight window when it is placed, and the tiles
// entering and leaving it as its center moves.
// A result is registered at the edge that steps the next hit of its scan (the
//   final one at the flush).
// Items are taken one at a time; the scan counter steps one candidate per cycle
//   over up to 25 tiles per window, 50 for a move, unless the output stalls it.
// Output back-pressure stalls the scan only when a hit meets a pending result.
// Reset: stored center (0,0), grid 1024 x 1024, radius 1; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_tile_visibility import swtv_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	swtv_in_if.sink                 item,
	swtv_out_if.source              result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [GRID_W-1:0]   grid_width_q;
	logic [GRID_W-1:0]   grid_height_q;
	logic [RADIUS_W-1:0] sight_radius_q;

	swtv_cmd_t cmd;
	swtv_sts_t sts;
	logic      idle;
	logic      item_fire;
	logic      wr_en;

	// --- configuration port: zero wait state, write in the access phase ---
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= GRID_WIDTH_RST;
			grid_height_q  <= GRID_HEIGHT_RST;
			sight_radius_q <= SIGHT_RADIUS_RST;
		end else if (wr_en) begin
			unique case (paddr)
				ADDR_GRID_WIDTH:   grid_width_q   <= pwdata[GRID_W-1:0];
				ADDR_GRID_HEIGHT:  grid_height_q  <= pwdata[GRID_W-1:0];
				ADDR_SIGHT_RADIUS: sight_radius_q <= pwdata[RADIUS_W-1:0];
				default: ;  // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_GRID_WIDTH:   prdata = 32'(grid_width_q);
			ADDR_GRID_HEIGHT:  prdata = 32'(grid_height_q);
			ADDR_SIGHT_RADIUS: prdata = 32'(sight_radius_q);
			default:           prdata = '0;
		endcase
	end

	// --- item channel: one item at a time, taken only while the sequencer rests ---
	assign item.ready = idle;
	assign item_fire  = item.valid && idle;

	swtv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_fire (item_fire),
		.sts       (sts),
		.idle      (idle),
		.cmd       (cmd)
	);

	// Datapath holds one result back so that the final one of an item can be
	// flagged last once the scan knows nothing follows it.
	swtv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item_action (item.action),
		.item_x      (item.center_x),
		.item_y      (item.center_y),
		.cfg_width   (grid_width_q),
		.cfg_height  (grid_height_q),
		.cfg_radius  (sight_radius_q),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.res_x       (result.tile_x),
		.res_y       (result.tile_y),
		.res_visible (result.page_visible),
		.res_last    (result.last)
	);

endmodule
`default_nettype wire

[rtl/swtv_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swtv_ctrl
// Sequencer: starts window scans, paces them against the output, flushes last.
// ----------------------------------------------------------------------------
module swtv_ctrl import swtv_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_fire,
	input  wire swtv_sts_t sts,
	output logic           idle,
	output swtv_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       can_step;

	// a hit displaces the pending result, which needs a free output slot
	assign can_step = !(sts.hit && sts.pend_valid && !sts.out_free);
	assign idle     = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (!sts.is_move) begin
					cmd.start_new = 1'b1;
					state_d       = ST_SCAN;
				end else if (sts.same_center) begin
					state_d = ST_IDLE;
				end else begin
					cmd.start_old = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (can_step) begin
					cmd.step = 1'b1;
					if (sts.at_end) begin
						if (sts.phase_old) begin
							cmd.start_new = 1'b1;
						end else begin
							state_d = ST_FLUSH;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush  = 1'b1;
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/swtv_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swtv_dp
// Window bounds, scan counters, overlap filter, pending and output registers.
// ----------------------------------------------------------------------------
module swtv_dp import swtv_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire swtv_cmd_t           cmd,
	output swtv_sts_t                sts,
	input  wire logic                item_action,
	input  wire logic [COORD_W-1:0]  item_x,
	input  wire logic [COORD_W-1:0]  item_y,
	input  wire logic [GRID_W-1:0]   cfg_width,
	input  wire logic [GRID_W-1:0]   cfg_height,
	input  wire logic [RADIUS_W-1:0] cfg_radius,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output logic [COORD_W-1:0]       res_x,
	output logic [COORD_W-1:0]       res_y,
	output logic                     res_visible,
	output logic                     res_last
);

	typedef struct packed {
		logic [SPAN_W-1:0] b;  // first tile
		logic [SPAN_W-1:0] e;  // one past last tile
	} span_t;

	function automatic span_t span_of(input logic [COORD_W-1:0] c,
	                                  input logic [RADIUS_W-1:0] r,
	                                  input logic [GRID_W-1:0] lim);
		span_t             s;
		logic [SPAN_W-1:0] cw;
		logic [SPAN_W-1:0] hi;
		cw  = SPAN_W'(c);
		hi  = cw + SPAN_W'(r) + SPAN_W'(1);
		s.b = (cw > SPAN_W'(r)) ? cw - SPAN_W'(r) : '0;
		s.e = (hi < SPAN_W'(lim)) ? hi : SPAN_W'(lim);
		return s;
	endfunction

	function automatic logic near(input logic [SPAN_W-1:0] a,
	                              input logic [COORD_W-1:0] c,
	                              input logic [RADIUS_W-1:0] r);
		logic [SPAN_W-1:0] cw;
		logic [SPAN_W-1:0] d;
		cw = SPAN_W'(c);
		d  = (a > cw) ? a - cw : cw - a;
		return d <= SPAN_W'(r);
	endfunction

	logic [GRID_W-1:0]   w_sat;
	logic [GRID_W-1:0]   h_sat;
	logic [RADIUS_W-1:0] r_sat;

	logic               act_q;
	logic [COORD_W-1:0] nx_q, ny_q;    // new center
	logic [COORD_W-1:0] px_q, py_q;    // stored center
	logic               phase_old_q;
	logic [SPAN_W-1:0]  x_q, y_q;
	logic               pend_valid_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic               pend_vis_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q, out_y_q;
	logic               out_vis_q, out_last_q;

	span_t old_sx, old_sy, new_sx, new_sy, cur_sx, cur_sy;
	logic  [COORD_W-1:0] fx, fy;
	logic  nonempty, in_rng, hit, at_end, out_free, push, x_wrap;

	assign w_sat = (cfg_width  > GRID_MAX)  ? GRID_MAX  : cfg_width;
	assign h_sat = (cfg_height > GRID_MAX)  ? GRID_MAX  : cfg_height;
	assign r_sat = (cfg_radius > MAX_SIGHT) ? MAX_SIGHT : cfg_radius;

	assign old_sx = span_of(px_q, r_sat, w_sat);
	assign old_sy = span_of(py_q, r_sat, h_sat);
	assign new_sx = span_of(nx_q, r_sat, w_sat);
	assign new_sy = span_of(ny_q, r_sat, h_sat);
	assign cur_sx = phase_old_q ? old_sx : new_sx;
	assign cur_sy = phase_old_q ? old_sy : new_sy;

	// old tiles are checked against the new center and the other way round
	assign fx = phase_old_q ? nx_q : px_q;
	assign fy = phase_old_q ? ny_q : py_q;

	assign nonempty = (cur_sx.b < cur_sx.e) && (cur_sy.b < cur_sy.e);
	assign in_rng   = near(x_q, fx, r_sat) && near(y_q, fy, r_sat);
	assign hit      = nonempty && !((act_q == ACT_MOVE) && in_rng);
	assign x_wrap   = (x_q == cur_sx.e - SPAN_W'(1));
	assign at_end   = !nonempty || (x_wrap && (y_q == cur_sy.e - SPAN_W'(1)));
	assign out_free = !out_valid_q || res_ready;
	assign push     = (cmd.step && hit && pend_valid_q) || cmd.flush;

	always_comb begin
		sts.is_move     = (act_q == ACT_MOVE);
		sts.same_center = (nx_q == px_q) && (ny_q == py_q);
		sts.phase_old   = phase_old_q;
		sts.hit         = hit;
		sts.at_end      = at_end;
		sts.pend_valid  = pend_valid_q;
		sts.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q         <= '0;
			py_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				px_q <= nx_q;
				py_q <= ny_q;
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.step && hit) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= item_action;
			nx_q  <= item_x;
			ny_q  <= item_y;
		end
		if (cmd.start_old) begin
			phase_old_q <= 1'b1;
			x_q         <= old_sx.b;
			y_q         <= old_sy.b;
		end else if (cmd.start_new) begin
			phase_old_q <= 1'b0;
			x_q         <= new_sx.b;
			y_q         <= new_sy.b;
		end else if (cmd.step) begin
			if (x_wrap) begin
				x_q <= cur_sx.b;
				y_q <= y_q + SPAN_W'(1);
			end else begin
				x_q <= x_q + SPAN_W'(1);
			end
		end
		if (cmd.step && hit) begin
			pend_x_q   <= x_q[COORD_W-1:0];
			pend_y_q   <= y_q[COORD_W-1:0];
			pend_vis_q <= !phase_old_q;
		end
		if (push) begin
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_vis_q  <= pend_vis_q;
			out_last_q <= cmd.flush;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_x       = out_x_q;
	assign res_y       = out_y_q;
	assign res_visible = out_vis_q;
	assign res_last    = out_last_q;

	a_flush_needs_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_valid_q)
		else $error("flush without pending result");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed into occupied output register");

	a_out_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (SPAN_W'(out_x_q) < SPAN_W'(w_sat))
			&& (SPAN_W'(out_y_q) < SPAN_W'(h_sat)))
		else $error("result tile outside grid");

endmodule
`default_nettype wire
